FILE: src/mip_box_downsample_assert.svh
// Assertion macros shared by the downsampler RTL.
// Each macro takes a label, a condition, a consequence and a message.
`ifndef MIP_BOX_DOWNSAMPLE_ASSERT_SVH
`define MIP_BOX_DOWNSAMPLE_ASSERT_SVH

// Consequence holds in the same cycle as the condition.
`define MBD_ASSERT_SAME(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Consequence holds in the cycle after the condition.
`define MBD_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

FILE: src/mbd_pkg.sv
`default_nettype none
package mbd_pkg;

  // Sizes
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 4096;
  localparam int SRC_W_BITS    = 12;
  localparam int SRC_H_BITS    = 13;
  localparam int ROW_BITS      = 12;
  localparam int ADDR_BITS     = 3;
  localparam int DATA_BITS     = 32;

  // Register reset values
  localparam logic [SRC_W_BITS-1:0] SRC_W_RESET = 12'd256;
  localparam logic [SRC_H_BITS-1:0] SRC_H_RESET = 13'd256;

  // Register indexes (paddr[2])
  localparam logic REG_SOURCE_WIDTH  = 1'b0;
  localparam logic REG_SOURCE_HEIGHT = 1'b1;

  // Output alpha, fully opaque
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // One source texel
  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } rgb_t;

  // Horizontal pair sum, 9 bits per channel
  typedef struct packed {
    logic [8:0] b;
    logic [8:0] g;
    logic [8:0] r;
  } pair_t;

endpackage
`default_nettype wire

FILE: src/mip_box_downsample.sv
`default_nettype none
// 2x2 box-filter mipmap downsampler, one level per pass.
// Input stream: one RGB source texel per beat in raster order,
//   s_tdata = {blue, green, red}. Output stream: one texel per 2x2 block,
//   m_tdata = {alpha, blue, green, red}, m_tlast on the last texel of the level.
// Each channel is the four-texel sum shifted right by two; alpha is 255.
// An odd last column or row is consumed and gives no output.
// APB registers: 0x0 source_width (clamped to 2..MAX_WIDTH), 0x4 source_height
//   (clamped to 2..4096). Any register write restarts the frame at row 0,
//   column 0; write only while the stream is idle.
// Throughput: one texel per cycle while s_tready is high. Accepting a block's
//   bottom-right texel loads the stage register, which then loads the output
//   register and raises m_tvalid; the line store read sits between the two.
// The line store holds MAX_WIDTH/2 pair sums, written on even rows and read
//   on odd rows; it needs no clearing.
// Reset restores 256x256, clears counters and empties the pipeline.
// When m_tready is low, the result waits in the output register while one more
//   block waits in the stage register; s_tready drops only when both are full.
module mip_box_downsample #(
  parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // APB configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mbd_pkg::ADDR_BITS-1:0]  paddr,
  input  wire logic [mbd_pkg::DATA_BITS-1:0]  pwdata,
  output logic      [mbd_pkg::DATA_BITS-1:0]  prdata,
  output logic                                pready,
  // Source texels
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [23:0]                    s_tdata,  // red_in, green_in, blue_in
  // Downsampled texels
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [31:0]                         m_tdata,  // red_out, green_out, blue_out, alpha_out
  output logic                                m_tlast   // frame_end
);
  import mbd_pkg::*;

  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int WW         = CW + 1;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int SW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  // Configuration registers
  logic [SRC_W_BITS-1:0] source_width;
  logic [SRC_H_BITS-1:0] source_height;
  logic                  cfg_write;

  // Position and pair state
  logic [CW-1:0]       col;
  logic [ROW_BITS-1:0] row;
  rgb_t                left_texel;

  // Stage register (waits for line store read data)
  logic  s1_valid;
  pair_t s1_pair;
  logic  s1_last;
  pair_t line_rd;

  // Line store
  pair_t line_mem [LINE_DEPTH];

  // Handshake
  logic  out_free;
  logic  s1_free;
  logic  accept;
  rgb_t  texel;

  // Geometry
  logic [WW-1:0]         used_w;
  logic [SRC_H_BITS-1:0] used_h;
  logic [WW-1:0]         w_even;
  logic [SRC_H_BITS-1:0] h_even;
  logic [WW-1:0]         col_inc;
  logic [SRC_H_BITS-1:0] row_inc;
  logic                  in_range;
  logic                  col_wrap;
  logic                  row_wrap;
  logic                  block_last;
  logic [SW-1:0]         slot;
  pair_t                 pair_now;
  logic                  line_wr;
  logic                  line_rd_en;

  // APB access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_SOURCE_WIDTH:  prdata = DATA_BITS'(source_width);
      REG_SOURCE_HEIGHT: prdata = DATA_BITS'(source_height);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SRC_W_RESET;
      source_height <= SRC_H_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_SOURCE_WIDTH:  source_width  <= pwdata[SRC_W_BITS-1:0];
        REG_SOURCE_HEIGHT: source_height <= pwdata[SRC_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp geometry
  always_comb begin
    if (32'(source_width) < 32'd2) begin
      used_w = WW'(2);
    end else if (32'(source_width) > 32'(MAX_WIDTH)) begin
      used_w = WW'(MAX_WIDTH);
    end else begin
      used_w = WW'(source_width);
    end
    if (source_height < SRC_H_BITS'(2)) begin
      used_h = SRC_H_BITS'(2);
    end else if (32'(source_height) > 32'(MAX_HEIGHT)) begin
      used_h = SRC_H_BITS'(MAX_HEIGHT);
    end else begin
      used_h = source_height;
    end
  end

  assign w_even     = {used_w[WW-1:1], 1'b0};
  assign h_even     = {used_h[SRC_H_BITS-1:1], 1'b0};
  assign col_inc    = {1'b0, col} + WW'(1);
  assign row_inc    = {1'b0, row} + SRC_H_BITS'(1);
  assign in_range   = ({1'b0, col} < w_even) && ({1'b0, row} < h_even);
  assign col_wrap   = col_inc >= used_w;
  assign row_wrap   = row_inc >= used_h;
  assign block_last = (col_inc == w_even) && (row_inc == h_even);
  assign slot       = SW'(col >> 1);

  // Handshake and pipeline flow
  assign out_free = !m_tvalid || m_tready;
  assign s1_free  = !s1_valid || out_free;
  assign s_tready = s1_free;
  assign accept   = s_tvalid && s_tready;
  assign texel    = s_tdata;

  // Pair sum of the left texel and the current one
  assign pair_now.r = {1'b0, left_texel.r} + {1'b0, texel.r};
  assign pair_now.g = {1'b0, left_texel.g} + {1'b0, texel.g};
  assign pair_now.b = {1'b0, left_texel.b} + {1'b0, texel.b};

  assign line_wr    = accept && in_range && col[0] && !row[0];
  assign line_rd_en = accept && in_range && col[0] && row[0];

  // Advance position counters; restart on any register write
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : row_inc[ROW_BITS-1:0];
      end else begin
        col <= col_inc[CW-1:0];
      end
    end
  end

  // Hold the left texel of a pair
  always_ff @(posedge clk) begin
    if (accept && !col[0]) begin
      left_texel <= texel;
    end
  end

  // Line store: write pair sums on even rows, read them back on odd rows
  always_ff @(posedge clk) begin
    if (line_wr) begin
      line_mem[slot] <= pair_now;
    end
    if (line_rd_en) begin
      line_rd <= line_mem[slot];
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (line_rd_en) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (line_rd_en) begin
      s1_pair <= pair_now;
      s1_last <= block_last;
    end
  end

  // Output register: add the upper pair and divide by four
  logic [9:0] sum_r;
  logic [9:0] sum_g;
  logic [9:0] sum_b;

  assign sum_r = {1'b0, line_rd.r} + {1'b0, s1_pair.r};
  assign sum_g = {1'b0, line_rd.g} + {1'b0, s1_pair.g};
  assign sum_b = {1'b0, line_rd.b} + {1'b0, s1_pair.b};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      m_tdata <= {ALPHA_OPAQUE, sum_b[9:2], sum_g[9:2], sum_r[9:2]};
      m_tlast <= s1_last;
    end
  end

  `include "mip_box_downsample_assert.svh"

  `MBD_ASSERT_SAME(a_pos_in_frame, 1'b1, ({1'b0, col} < used_w) && ({1'b0, row} < used_h), "position outside the frame")
  `MBD_ASSERT_NEXT(a_block_to_stage, line_rd_en, s1_valid, "bottom-right texel did not reach the stage register")
  `MBD_ASSERT_NEXT(a_stage_to_out, s1_valid && out_free, m_tvalid, "stage register result lost")
  `MBD_ASSERT_NEXT(a_stage_holds, s1_valid && !out_free, s1_valid && $stable(s1_pair), "stalled stage register changed")

endmodule
`default_nettype wire

FILE: test/mip_box_downsample_checker.sv
module mip_box_downsample_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mbd_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [mbd_pkg::DATA_BITS-1:0] pwdata,
  input  wire logic [mbd_pkg::DATA_BITS-1:0] prdata,
  input  wire logic                          pready,
  input  wire logic                          s_tvalid,
  input  wire logic                          s_tready,
  input  wire logic [23:0]                   s_tdata,  // red_in, green_in, blue_in
  input  wire logic                          m_tvalid,
  input  wire logic                          m_tready,
  input  wire logic [31:0]                   m_tdata,  // red_out, green_out, blue_out, alpha_out
  input  wire logic                          m_tlast,  // frame_end
  output int                                 failures,
  output int                                 pending
);
  import mbd_pkg::*;

  // Pair sums of the even row, 10 bits per channel
  typedef struct packed {
    logic [9:0] b;
    logic [9:0] g;
    logic [9:0] r;
  } line_sum_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       frame_end;
  } mip_texel_t;

  logic [SRC_W_BITS-1:0] width_reg;
  logic [SRC_H_BITS-1:0] height_reg;
  logic [10:0]           col_pos;
  logic [11:0]           row_pos;
  pair_t                 left_pair;
  line_sum_t             line_store [MAX_WIDTH_DEF/2];
  mip_texel_t            mip_texels [$];

  assign pending = mip_texels.size();

  function automatic int clamp_size(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Fold one source texel into the block sums; queue a texel on each bottom-right corner
  task automatic filter_texel(input rgb_t px);
    int w, h, col, row, last_col, last_row, slot;
    int sum_r, sum_g, sum_b;
    pair_t pair;
    line_sum_t above;
    mip_texel_t t;
    w = clamp_size(int'(width_reg), 2, MAX_WIDTH_DEF);
    h = clamp_size(int'(height_reg), 2, MAX_HEIGHT);
    col = int'(col_pos);
    row = int'(row_pos);
    last_col = (w & ~1) - 1;
    last_row = (h & ~1) - 1;
    if (col <= last_col && row <= last_row) begin
      if (col % 2 == 0) begin
        left_pair = '{b: 9'(px.b), g: 9'(px.g), r: 9'(px.r)};
      end else begin
        pair.r = left_pair.r + px.r;
        pair.g = left_pair.g + px.g;
        pair.b = left_pair.b + px.b;
        slot = col / 2;
        if (row % 2 == 0) begin
          line_store[slot] = '{b: 10'(pair.b), g: 10'(pair.g), r: 10'(pair.r)};
        end else begin
          above = line_store[slot];
          sum_r = int'(above.r) + int'(pair.r);
          sum_g = int'(above.g) + int'(pair.g);
          sum_b = int'(above.b) + int'(pair.b);
          t.red = 8'(sum_r >> 2);
          t.green = 8'(sum_g >> 2);
          t.blue = 8'(sum_b >> 2);
          t.alpha = ALPHA_OPAQUE;
          t.frame_end = (col == last_col && row == last_row);
          mip_texels.push_back(t);
        end
      end
    end
    // Advance raster position, wrap at end of frame
    if (col + 1 >= w) begin
      col_pos = '0;
      row_pos = (row + 1 >= h) ? '0 : 12'(row + 1);
    end else begin
      col_pos = 11'(col + 1);
    end
  endtask

  task automatic compare_texel();
    mip_texel_t want;
    if (mip_texels.size() == 0) begin
      $error("output beat with no texel expected: m_tdata %h m_tlast %b", m_tdata, m_tlast);
      failures++;
    end else begin
      want = mip_texels.pop_front();
      if (m_tdata[7:0] !== want.red) begin
        $error("red_out: expected %0d, actual %0d", want.red, m_tdata[7:0]);
        failures++;
      end
      if (m_tdata[15:8] !== want.green) begin
        $error("green_out: expected %0d, actual %0d", want.green, m_tdata[15:8]);
        failures++;
      end
      if (m_tdata[23:16] !== want.blue) begin
        $error("blue_out: expected %0d, actual %0d", want.blue, m_tdata[23:16]);
        failures++;
      end
      if (m_tdata[31:24] !== want.alpha) begin
        $error("alpha_out: expected %0d, actual %0d", want.alpha, m_tdata[31:24]);
        failures++;
      end
      if (m_tlast !== want.frame_end) begin
        $error("frame_end: expected %0d, actual %0d", want.frame_end, m_tlast);
        failures++;
      end
    end
  endtask

  // Watch the register port and both streams
  always @(posedge clk) begin
    logic [DATA_BITS-1:0] reg_value;
    if (rst) begin
      width_reg = SRC_W_RESET;
      height_reg = SRC_H_RESET;
      col_pos = '0;
      row_pos = '0;
      left_pair = '0;
      mip_texels.delete();
      failures = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_SOURCE_HEIGHT) height_reg = pwdata[SRC_H_BITS-1:0];
          else width_reg = pwdata[SRC_W_BITS-1:0];
          // Any write restarts the frame
          col_pos = '0;
          row_pos = '0;
          left_pair = '0;
        end else begin
          reg_value = (paddr[2] == REG_SOURCE_HEIGHT) ? DATA_BITS'(height_reg) :
                                                        DATA_BITS'(width_reg);
          if (prdata !== reg_value) begin
            $error("prdata: expected %0d, actual %0d", reg_value, prdata);
            failures++;
          end
        end
      end
      if (s_tvalid && s_tready) filter_texel(rgb_t'(s_tdata));
      if (m_tvalid && m_tready) compare_texel();
    end
  end

endmodule

FILE: test/tb_mip_box_downsample.sv
module tb_mip_box_downsample;
  import mbd_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 1500;
  localparam int RANDOM_TEXELS   = 80;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [23:0]          s_tdata;  // red_in, green_in, blue_in
  logic                 m_tvalid;
  logic                 m_tready;
  logic [31:0]          m_tdata;  // red_out, green_out, blue_out, alpha_out
  logic                 m_tlast;  // frame_end

  int check_failures;
  int mip_pending;
  int idle_cycles;
  bit sender_steady;
  bit rx_steady;
  bit squeeze_now;

  mip_box_downsample dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  mip_box_downsample_checker texel_check (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .failures (check_failures),
    .pending  (mip_pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic rgb_t rand_texel();
    rgb_t px;
    px = rgb_t'(24'($urandom));
    if ($urandom_range(0, 9) == 0) px = $urandom_range(0, 1) ? '1 : '0;
    return px;
  endfunction

  // Offer one texel beat; entered and left at a falling edge
  task automatic send_texel(input rgb_t px);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // One APB transfer: setup, access, then idle with psel low
  task automatic apb_access(input bit is_write, input logic idx, input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value) | ($urandom << 13);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid and let the pipeline drain
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (mip_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(input int w, input int h);
    wait_idle();
    sender_steady = ($urandom_range(0, 4) == 0);
    rx_steady = ($urandom_range(0, 4) == 0);
    apb_access(1'b1, REG_SOURCE_WIDTH, w);
    apb_access(1'b1, REG_SOURCE_HEIGHT, h);
    apb_access(1'b0, REG_SOURCE_WIDTH, 0);
    apb_access(1'b0, REG_SOURCE_HEIGHT, 0);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_texel(rand_texel());
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_now) begin
        squeeze_now = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        m_tready <= 1'b1;
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        if (!rx_steady) stall = pick_gap();
      end
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int sent;
    int w;
    int h;
    bit in_block;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    idle_cycles = 0;
    sender_steady = 1'b0;
    rx_steady = 1'b0;
    squeeze_now = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset sizes: read back, then a row and a part at 256 wide; hold the output off in row one
    apb_access(1'b0, REG_SOURCE_WIDTH, 0);
    apb_access(1'b0, REG_SOURCE_HEIGHT, 0);
    for (int i = 0; i < 320; i++) begin
      if (i == 280) squeeze_now = 1'b1;
      send_texel(rand_texel());
    end

    // Odd sizes: the odd column and row must not leak into the block; two frames
    configure(3, 3);
    for (int k = 0; k < 18; k++) begin
      in_block = (k % 3 < 2) && ((k % 9) / 3 < 2);
      send_texel((in_block ^ (k >= 9)) ? '1 : '0);
    end

    // Sizes below range clamp to 2x2; sums that truncate
    configure(0, 1);
    send_texel('{b: 8'hFF, g: 8'hAA, r: 8'h01});
    send_texel('{b: 8'hFF, g: 8'h55, r: 8'h01});
    send_texel('{b: 8'hFF, g: 8'hAA, r: 8'h01});
    send_texel('{b: 8'hFE, g: 8'h55, r: 8'h00});

    // Width above range clamps to MAX_WIDTH, only the start of row zero
    configure(4095, 2);
    send_random(40);

    // Tallest frame, only its first rows
    configure(2, 8191);
    send_random(40);

    // Random sizes, mostly small
    sent = 0;
    while (sent < RANDOM_TEXELS) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(0, 16);
      h = ($urandom_range(0, 19) == 0) ? $urandom_range(4096, 8191) : $urandom_range(0, 10);
      configure(w, h);
      w = $urandom_range(4, 60);
      send_random(w);
      sent += w;
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (check_failures == 0 && mip_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/mbd_pkg.sv
src/mip_box_downsample.sv
test/mip_box_downsample_checker.sv
test/tb_mip_box_downsample.sv
